FILE: rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/serpent_pkg.sv
package serpent_pkg;
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ENC  = 2'd1;
  localparam logic [1:0] OP_DEC  = 2'd2;
  localparam int unsigned KeyWords = 132;
  localparam int unsigned KeyRows  = 33;
  localparam int unsigned NumLanes = 32;

  typedef logic [3:0][31:0] blk_t;

  localparam logic [7:0][63:0] SboxFwd = {
    64'h6539_AC47_B28E_0FD1, 64'h0A3D_F19E_B648_5C27, 64'h176D_8E30_C9A4_B25F,
    64'hD7E9_A452_6B0C_38F1, 64'hE57A_421D_369C_8BF0, 64'h25B0_4E1D_FAC3_9768,
    64'h43D6_8EB1_A509_72CF, 64'hC907_24DE_B56A_1F83
  };
  localparam logic [7:0][63:0] SboxInv = {
    64'h241A_7BC5_8FE9_D603, 64'hB8C2_7E94_0635_D1AF, 64'h0AC7_356B_ED14_92F8,
    64'h1DF4_6BC2_E79A_3805, 64'h1F84_2C53_D6EB_7A90, 64'h7A85_D630_21EB_4F9C,
    64'h0AD1_974B_3C6F_E285, 64'h289F_74E1_C56A_0B3D
  };

  function automatic logic [3:0] sbox_lookup(input logic dec, input logic [2:0] sel,
                                             input logic [3:0] nib);
    logic [63:0] row;
    row = dec ? SboxInv[sel] : SboxFwd[sel];
    return row[{nib, 2'b00} +: 4];
  endfunction
endpackage

FILE: rtl/serpent_lane.sv
module serpent_lane (
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       en_i,
  input  logic [3:0] load_nib_i,
  input  logic       dec_i,
  input  logic [2:0] sel_i,
  input  logic [3:0] key_nib_i,
  input  logic [3:0] post_nib_i,
  output logic [3:0] sbox_nib_o,
  output logic [3:0] nib_o
);
  logic [3:0] nib_q, nib_d;

  // decrypt: inverse S-box then key mix; encrypt: key mix then S-box
  always_comb begin
    if (dec_i) sbox_nib_o = serpent_pkg::sbox_lookup(1'b1, sel_i, nib_q) ^ key_nib_i;
    else sbox_nib_o = serpent_pkg::sbox_lookup(1'b0, sel_i, nib_q ^ key_nib_i);
  end

  always_comb begin
    if (load_i) nib_d = load_nib_i;
    else if (en_i) nib_d = post_nib_i;
    else nib_d = nib_q;
  end

  always_ff @(posedge clk_i) begin
    nib_q <= nib_d;
  end

  assign nib_o = nib_q;
endmodule

FILE: rtl/serpent_lin.sv
module serpent_lin (
  input  logic               fwd_i,
  input  serpent_pkg::blk_t  w_i,
  output serpent_pkg::blk_t  w_o
);
  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  logic [31:0] a0, a1, a2, a3, b0, b1, b2, b3, c0, c1, c2, c3, d0, d1, d2, d3;
  always_comb begin
    a0 = rol(w_i[0], 13);
    a2 = rol(w_i[2], 3);
    a1 = rol(w_i[1] ^ a0 ^ a2, 1);
    a3 = rol(w_i[3] ^ a2 ^ (a0 << 3), 7);
    b0 = rol(a0 ^ a1 ^ a3, 5);
    b2 = rol(a2 ^ a3 ^ (a1 << 7), 22);
    c2 = rol(w_i[2], 10);
    c0 = rol(w_i[0], 27);
    c2 = c2 ^ w_i[3] ^ (w_i[1] << 7);
    c0 = c0 ^ w_i[1] ^ w_i[3];
    c3 = rol(w_i[3], 25);
    c1 = rol(w_i[1], 31);
    c3 = c3 ^ c2 ^ (c0 << 3);
    c1 = c1 ^ c0 ^ c2;
    d2 = rol(c2, 29);
    d0 = rol(c0, 19);
    d1 = c1;
    d3 = c3;
    if (fwd_i) w_o = {a3, b2, a1, b0};
    else w_o = {d3, d2, d1, d0};
  end
endmodule

FILE: rtl/serpent_block_cipher_top.sv
// An accepted encrypt/decrypt transaction runs 32 S-box rounds plus one key-mix-only
// step, one step per cycle, and then raises m_axis_tvalid. s_axis_tready stays low
// while the steps run, so no new block is accepted until the result is in the output
// register; the last step holds while that register is full and m_axis_tready is low.
// Key loads and unused opcodes give no result and leave the block idle.
// Reset (rst_ni, async low) clears control only; the round-key store is not cleared.
`include "assert_macros.svh"
module serpent_block_cipher_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[1:0], key_slot[9:2], key_word[41:10], block_low[105:42],
  // block_high[169:106], zero pad [175:170]
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_low[63:0], result_high[127:64]
  output logic [127:0] m_axis_tdata
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;

  logic [1:0] st_q, st_d;
  logic [5:0] rnd_q, rnd_d;
  logic       dec_q, dec_d;
  logic       out_vld_q, out_vld_d;
  serpent_pkg::blk_t key_q;
  logic [127:0] res_q;
  serpent_pkg::blk_t mem_q [serpent_pkg::KeyRows];
  logic [5:0]   key_row;

  wire acc = s_axis_tvalid && s_axis_tready;
  wire [1:0] op = s_axis_tdata[1:0];
  wire [7:0] slot = s_axis_tdata[9:2];
  wire start = acc && (op == serpent_pkg::OP_ENC || op == serpent_pkg::OP_DEC);
  wire last = (st_q == ST_RUN) && (rnd_q == 6'd32);
  wire stall = last && out_vld_q && !m_axis_tready;
  wire adv = (st_q == ST_RUN) && !stall;

  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;

  // round-key row read: enc rows 0..32, dec rows 32..0; registered ahead into key_q
  always_comb begin
    if (st_q == ST_IDLE) key_row = (op == serpent_pkg::OP_DEC) ? 6'd32 : 6'd0;
    else key_row = dec_q ? 6'(6'd31 - rnd_q) : 6'(rnd_q + 6'd1);
  end

  always_ff @(posedge clk_i) begin
    if (acc && op == serpent_pkg::OP_LOAD && slot < 8'(serpent_pkg::KeyWords))
      mem_q[slot[7:2]][slot[1:0]] <= s_axis_tdata[41:10];
    if (key_row <= 6'd32)
      key_q <= mem_q[key_row];
  end

  // enc step r<32: km, sbox, lin (r<31); step 32: final km
  // dec step 0: km32; step k>=1, r=32-k: sbox_inv, km r, lin_inv (r>0)
  serpent_pkg::blk_t w_cur, sb_out, lin_out, post;
  logic [2:0] sel;
  logic       km_only, lin_en;
  logic [3:0] lane_nib [serpent_pkg::NumLanes];
  logic [3:0] sbox_nib [serpent_pkg::NumLanes];

  always_comb begin
    km_only = dec_q ? (rnd_q == 6'd0) : (rnd_q == 6'd32);
    lin_en  = dec_q ? (rnd_q < 6'd32) : (rnd_q < 6'd31);
    sel     = dec_q ? 3'(6'd32 - rnd_q) : rnd_q[2:0];
  end

  always_comb begin
    for (int j = 0; j < 32; j++)
      for (int i = 0; i < 4; i++) begin
        w_cur[i][j]  = lane_nib[j][i];
        sb_out[i][j] = sbox_nib[j][i];
      end
  end

  serpent_lin u_lin (.fwd_i(!dec_q), .w_i(sb_out), .w_o(lin_out));

  always_comb begin
    if (km_only) post = w_cur ^ key_q;
    else if (lin_en) post = lin_out;
    else post = sb_out;
  end

  for (genvar j = 0; j < serpent_pkg::NumLanes; j++) begin : g_lane
    logic [3:0] ld, kn, pn;
    assign ld = {s_axis_tdata[106+32+j], s_axis_tdata[106+j],
                 s_axis_tdata[42+32+j], s_axis_tdata[42+j]};
    assign kn = {key_q[3][j], key_q[2][j], key_q[1][j], key_q[0][j]};
    assign pn = {post[3][j], post[2][j], post[1][j], post[0][j]};
    serpent_lane u_lane (
      .clk_i, .load_i(start), .en_i(adv), .load_nib_i(ld), .dec_i(dec_q),
      .sel_i(sel), .key_nib_i(kn), .post_nib_i(pn), .sbox_nib_o(sbox_nib[j]),
      .nib_o(lane_nib[j])
    );
  end

  always_comb begin
    st_d = st_q; rnd_d = rnd_q; dec_d = dec_q;
    out_vld_d = out_vld_q;
    if (m_axis_tready) out_vld_d = 1'b0;
    case (st_q)
      ST_IDLE: if (start) begin
        st_d = ST_RUN; rnd_d = '0; dec_d = (op == serpent_pkg::OP_DEC);
      end
      ST_RUN: if (!stall) begin
        rnd_d = 6'(rnd_q + 6'd1);
        if (last) begin
          st_d = ST_IDLE; out_vld_d = 1'b1;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; rnd_q <= '0; dec_q <= 1'b0; out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d; rnd_q <= rnd_d; dec_q <= dec_d; out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last && !stall)
      res_q <= post;
  end

  `ASSERT_IMPL(a_no_in_busy, clk_i, rst_ni, (st_q != ST_IDLE) |-> !s_axis_tready)
  `ASSERT_NEXT(a_done, clk_i, rst_ni, last, m_axis_tvalid)
  `ASSERT_NEXT(a_start, clk_i, rst_ni, start, (st_q == ST_RUN && rnd_q == 6'd0))
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready), m_axis_tvalid)
endmodule
